// ===== rtl/core/pse_pkg.sv =====
package pse_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 1024;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = 11;

    // Divider
    localparam int DIV_STEPS = 32;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // Token kinds
    localparam logic [2:0] KIND_NUMBER = 3'd0;
    localparam logic [2:0] KIND_ADD    = 3'd1;
    localparam logic [2:0] KIND_SUB    = 3'd2;
    localparam logic [2:0] KIND_MUL    = 3'd3;
    localparam logic [2:0] KIND_DIV    = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_DIVZERO   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    typedef struct packed {
        logic [2:0]          req_type;
        logic signed [31:0]  number_value;
        logic                end_of_expression;
    } req_t;

    typedef struct packed {
        logic signed [31:0]  result_value;
        logic [1:0]          status;
        logic [DEPTH_W-1:0]  leftover_depth;
    } rsp_t;

endpackage

// ===== rtl/core/postfix_stack_evaluator_top.sv =====
// Postfix integer expression evaluator.
//
// Request channel (req_valid / req_stall / req): one parsed token per
// transaction: a number, or an add, subtract, multiply or divide operator,
// with a flag that marks the final token of the expression.
// Response channel (rsp_valid / rsp_stall / rsp): one transaction per
// expression, sent after its final token: top of stack, sticky status and
// the number of values left on the stack. The stack and status then clear.
//
// Timing: req_stall is high while a token is worked on. A number, an unused
// kind or an operator short of operands passes through EXEC and FINISH; add,
// subtract, multiply and divide by zero also pass through OPER; other divides
// run OPER, DIV, DIVFIX and FINISH, as a restoring divider retires one quotient bit
// per cycle. The response is registered in FINISH for the final token.
//
// The response is held in an output register, so a new token is taken while
// an earlier response waits. If the receiver stalls and another final token
// completes, the block holds that token until the register frees up.
// Reset clears the stack pointer, status and the response valid flag; stack memory
// contents are left as they are and are never used before being written.
module postfix_stack_evaluator_top
    import pse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_OPER,
        S_DIV,
        S_DIVFIX,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    req_t                tok_reg, tok_next;
    logic [SP_W-1:0]     sp_reg, sp_next;
    logic [1:0]          err_reg, err_next;
    logic [31:0]         top_reg, top_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    // Divider state
    logic [32:0]         div_rem_reg, div_rem_next;
    logic [31:0]         div_quot_reg, div_quot_next;
    logic [31:0]         div_dvsr_reg, div_dvsr_next;
    logic                div_neg_reg, div_neg_next;
    logic [DCNT_W-1:0]   div_cnt_reg, div_cnt_next;

    // Stack memory: entries below sp-1; the top entry lives in top_reg
    logic [31:0]         stack_mem [STACK_DEPTH];
    logic [31:0]         rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic                wr_en;

    logic [31:0]         op_a;
    logic [31:0]         op_b;
    logic [32:0]         rem_shift;
    logic [32:0]         rem_diff;
    logic [SP_W-1:0]     sp_below_top;
    logic [SP_W-1:0]     sp_second;

    assign op_a         = rd_data_reg;
    assign op_b         = top_reg;
    assign rem_shift    = {div_rem_reg[31:0], div_quot_reg[31]};
    assign rem_diff     = rem_shift - {1'b0, div_dvsr_reg};
    assign sp_below_top = sp_reg - SP_W'(1);
    assign sp_second    = sp_reg - SP_W'(2);
    assign rd_addr      = sp_second[ADDR_W-1:0];
    assign wr_addr      = sp_below_top[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= top_reg;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        tok_next       = tok_reg;
        sp_next        = sp_reg;
        err_next       = err_reg;
        top_next       = top_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        div_rem_next   = div_rem_reg;
        div_quot_next  = div_quot_reg;
        div_dvsr_next  = div_dvsr_reg;
        div_neg_next   = div_neg_reg;
        div_cnt_next   = div_cnt_reg;
        wr_en          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    tok_next   = req;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_FINISH;
                case (tok_reg.req_type) inside
                    KIND_NUMBER:
                    begin
                        if (sp_reg >= SP_W'(STACK_DEPTH))
                        begin
                            if (err_reg == ST_OK)
                            begin
                                err_next = ST_OVERFLOW;
                            end
                        end
                        else
                        begin
                            // spill the old top into memory
                            wr_en    = (sp_reg != '0);
                            top_next = tok_reg.number_value;
                            sp_next  = sp_reg + SP_W'(1);
                        end
                    end
                    KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV:
                    begin
                        if (sp_reg < SP_W'(2))
                        begin
                            if (err_reg == ST_OK)
                            begin
                                err_next = ST_UNDERFLOW;
                            end
                        end
                        else
                        begin
                            // left operand read is in flight
                            state_next = S_OPER;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_OPER:
            begin
                state_next = S_FINISH;
                sp_next    = sp_below_top;
                case (tok_reg.req_type)
                    KIND_ADD: top_next = op_a + op_b;
                    KIND_SUB: top_next = op_a - op_b;
                    KIND_MUL: top_next = op_a * op_b;
                    default:
                    begin
                        if (op_b == '0)
                        begin
                            top_next = '0;
                            if (err_reg == ST_OK)
                            begin
                                err_next = ST_DIVZERO;
                            end
                        end
                        else
                        begin
                            // divide magnitudes, fix the sign at the end
                            sp_next       = sp_reg;
                            div_rem_next  = '0;
                            div_quot_next = op_a[31] ? -op_a : op_a;
                            div_dvsr_next = op_b[31] ? -op_b : op_b;
                            div_neg_next  = op_a[31] ^ op_b[31];
                            div_cnt_next  = '0;
                            state_next    = S_DIV;
                        end
                    end
                endcase
            end

            S_DIV:
            begin
                if (!rem_diff[32])
                begin
                    div_rem_next  = rem_diff;
                    div_quot_next = {div_quot_reg[30:0], 1'b1};
                end
                else
                begin
                    div_rem_next  = rem_shift;
                    div_quot_next = {div_quot_reg[30:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + DCNT_W'(1);
                if (div_cnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DIVFIX;
                end
            end

            S_DIVFIX:
            begin
                top_next   = div_neg_reg ? -div_quot_reg : div_quot_reg;
                sp_next    = sp_below_top;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!tok_reg.end_of_expression)
                begin
                    state_next = S_IDLE;
                end
                else if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.leftover_depth = DEPTH_W'(sp_reg);
                    if (sp_reg == '0)
                    begin
                        rsp_next.result_value = '0;
                        rsp_next.status = (err_reg == ST_OK) ? ST_UNDERFLOW : err_reg;
                    end
                    else
                    begin
                        rsp_next.result_value = top_reg;
                        rsp_next.status       = err_reg;
                    end
                    rsp_valid_next = 1'b1;
                    sp_next        = '0;
                    err_next       = ST_OK;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tok_reg       <= '0;
            sp_reg        <= '0;
            err_reg       <= ST_OK;
            top_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            div_rem_reg   <= '0;
            div_quot_reg  <= '0;
            div_dvsr_reg  <= '0;
            div_neg_reg   <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            tok_reg       <= tok_next;
            sp_reg        <= sp_next;
            err_reg       <= err_next;
            top_reg       <= top_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
            div_rem_reg   <= div_rem_next;
            div_quot_reg  <= div_quot_next;
            div_dvsr_reg  <= div_dvsr_next;
            div_neg_reg   <= div_neg_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    // Take a token only when the sequencer is free
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/core/pse_checker.sv =====
module pse_checker
    import pse_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // Hold a stalled response transaction
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // Busy in the cycle after each accepted token
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("token accepted back to back");

    // Depth never exceeds the stack size
    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.leftover_depth <= DEPTH_W'(STACK_DEPTH))
        else $error("leftover depth beyond stack size");

    // An empty stack at the end is always reported as an error
    a_empty_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_OK |-> rsp.leftover_depth != '0)
        else $error("ok status with empty stack");

endmodule

bind postfix_stack_evaluator_top pse_checker u_pse_checker (.*);
